// File: design/edge_clip_to_rect_core_macros.svh
// Assertion macros used by the edge clipper top level.
`ifndef EDGE_CLIP_TO_RECT_CORE_MACROS_SVH
`define EDGE_CLIP_TO_RECT_CORE_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define ECR_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define ECR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: design/ecr_pkg.sv
// Shared types, constants and arithmetic helpers of the edge clipper.
package ecr_pkg;

    // Fixed point format and coordinate width.
    localparam int FRAC_BITS = 16;
    localparam int CW        = 32;

    // Divider geometry: a 66-bit dividend, a 33-bit divisor and 35 quotient bits.
    localparam int QW     = 35;
    localparam int DVD_W  = 2 * (CW + 1);
    localparam int DVS_W  = CW + 1;
    localparam int REM_W  = DVS_W + 1;

    // The interpolation product is split on the second operand at this bit.
    localparam int MUL_LO_W = 16;
    localparam int PL_W     = CW + 1 + MUL_LO_W;
    localparam int PH_W     = CW + 1 + (CW + 1 - MUL_LO_W);

    // Polyline output.
    localparam int NPTS    = 5;
    localparam int CNT_W   = 3;
    localparam logic [CNT_W-1:0] MIN_PTS = CNT_W'(2);

    // Offset cap before saturation, and slope magnitude limits.
    localparam logic [QW-1:0] OFF_CAP  = QW'(64'h4_0000_0000);
    localparam logic [QW-1:0] SMAG_NEG = QW'(64'h8000_0000);
    localparam logic [QW-1:0] SMAG_POS = QW'(64'h7FFF_FFFF);

    // Configuration register indexes.
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TOP    = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT  = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_BOTTOM = CFG_IDX_W'(3);

    typedef logic signed [CW-1:0] coord_t;
    typedef logic signed [CW:0]   diff_t;

    // Everything an item carries down the pipeline.
    typedef struct packed {
        logic   vis;
        logic   sneg;
        logic   all_left;
        logic   all_right;
        logic   need_l;
        logic   need_r;
        logic   ineg;
        logic   da_zero;
        logic   cut_top;
        logic   cut_bot;
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        coord_t y0o;
        coord_t ycl;
    } ecr_item_t;

    // Sign extension by one bit, for exact differences.
    function automatic diff_t ext(coord_t v);
        return {v[CW-1], v};
    endfunction

    // Magnitude of a difference of two coordinates.
    function automatic logic [CW:0] mag(diff_t v);
        logic [CW:0] r;
        r = v[CW] ? (CW+1)'(-v) : (CW+1)'(v);
        return r;
    endfunction

    // Quotient capped at the offset limit; overflow means it is above the limit.
    function automatic logic [QW-1:0] cap_q(logic [QW-1:0] q, logic ovf);
        return (ovf || (q > OFF_CAP)) ? OFF_CAP : q;
    endfunction

    // Wide product capped at the offset limit.
    function automatic logic [QW-1:0] cap64(logic [2*CW-1:0] v);
        return (v > (2*CW)'(OFF_CAP)) ? OFF_CAP : v[QW-1:0];
    endfunction

    // base plus or minus a capped offset, saturated to 32 bits.
    function automatic coord_t add_sat(coord_t base, logic [QW-1:0] off, logic neg);
        logic signed [QW+1:0] b;
        logic signed [QW+1:0] o;
        logic signed [QW+1:0] s;
        coord_t r;
        b = {{(QW+2-CW){base[CW-1]}}, base};
        o = {2'b00, off};
        s = neg ? (b - o) : (b + o);
        if (s[QW+1:CW-1] == '0 || s[QW+1:CW-1] == '1)
        begin
            r = s[CW-1:0];
        end
        else if (s[QW+1])
        begin
            r = {1'b1, {(CW-1){1'b0}}};
        end
        else
        begin
            r = {1'b0, {(CW-1){1'b1}}};
        end
        return r;
    endfunction

endpackage

// File: design/ecr_seg_if.sv
// Segment input channel: valid, ready and the two end points.
interface ecr_seg_if;
    import ecr_pkg::*;

    logic   valid;
    logic   ready;
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink (input valid, input start_x, input start_y, input end_x,
                  input end_y, output ready);
endinterface

// File: design/ecr_pt_if.sv
// Point output channel: valid, ready and one polyline point.
interface ecr_pt_if;
    import ecr_pkg::*;

    logic   valid;
    logic   ready;
    coord_t point_x;
    coord_t point_y;
    logic   last_point;

    modport source (output valid, output point_x, output point_y, output last_point,
                    input ready);
    modport sink (input valid, input point_x, input point_y, input last_point,
                  output ready);
endinterface

// File: design/ecr_div.sv
// Pipelined restoring divider, one quotient bit per stage, with item sideband.
module ecr_div
    import ecr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              en,
    input  logic              in_valid,
    input  logic [DVD_W-1:0]  dividend,
    input  logic [DVS_W-1:0]  divisor,
    input  ecr_item_t         in_item,
    output logic              out_valid,
    output logic [QW-1:0]     quotient,
    output logic              ovf,
    output ecr_item_t         out_item
);

    logic [QW:0]       valid_reg;
    logic [REM_W-1:0]  rem_reg  [0:QW];
    logic [QW-1:0]     low_reg  [0:QW];
    logic [DVS_W-1:0]  dvs_reg  [0:QW];
    logic [QW:1]       ovf_reg;
    ecr_item_t         item_reg [0:QW];

    // Valid bits travel with the data.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[QW-1:0], in_valid};
        end
    end

    // Input stage: the top dividend bits form the first partial remainder.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= REM_W'(dividend[DVD_W-1:QW]);
            low_reg[0]  <= dividend[QW-1:0];
            dvs_reg[0]  <= divisor;
            item_reg[0] <= in_item;
        end
    end

    // One quotient bit per stage.
    for (genvar k = 0; k < QW; k++)
    begin : g_step
        logic [REM_W-1:0] sh;
        logic             ge;

        always_comb
        begin
            sh = {rem_reg[k][REM_W-2:0], low_reg[k][QW-1]};
            ge = sh >= {1'b0, dvs_reg[k]};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[k+1]  <= ge ? (sh - {1'b0, dvs_reg[k]}) : sh;
                low_reg[k+1]  <= {low_reg[k][QW-2:0], ge};
                dvs_reg[k+1]  <= dvs_reg[k];
                item_reg[k+1] <= item_reg[k];
            end
        end

        // The quotient does not fit when the first remainder already reaches the divisor.
        if (k == 0)
        begin : g_ovf_first
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ovf_reg[1] <= rem_reg[0] >= {1'b0, dvs_reg[0]};
                end
            end
        end
        else
        begin : g_ovf_pass
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    ovf_reg[k+1] <= ovf_reg[k];
                end
            end
        end
    end

    assign out_valid = valid_reg[QW];
    assign quotient  = low_reg[QW];
    assign ovf       = ovf_reg[QW];
    assign out_item  = item_reg[QW];

endmodule

// File: design/edge_clip_to_rect_core.sv
// Top level of the edge clipper: rectangle registers, clipping pipeline and point output.
//
// Each segment item is clipped against the rectangle held in clip_left, clip_top,
// clip_right and clip_bottom and gives a polyline of two to five points, one point per
// cycle on pt_out while it is ready, the final one marked by last_point; a horizontal
// segment or one wholly above or below the rectangle gives none. A segment enters in
// every cycle the pipeline advances, that is while the output register is empty or its
// last point is taken, so a rejected segment does not hold the block, and the output
// register, sending one point a cycle, sets the sustained segment rate. Most of the path
// to the first point lies in three 36-stage dividers in series (slope, left cut, right
// cut). When pt_out stalls, the whole pipeline holds and seg_in.ready falls.
module edge_clip_to_rect_core
    import ecr_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CW-1:0]         cfg_data,
    ecr_seg_if.sink               seg_in,
    ecr_pt_if.source              pt_out
);

    // Rectangle registers.
    coord_t clip_left_reg;
    coord_t clip_top_reg;
    coord_t clip_right_reg;
    coord_t clip_bottom_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_left_reg   <= '0;
            clip_top_reg    <= '0;
            clip_right_reg  <= '0;
            clip_bottom_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_LEFT:   clip_left_reg   <= cfg_data;
                REG_TOP:    clip_top_reg    <= cfg_data;
                REG_RIGHT:  clip_right_reg  <= cfg_data;
                REG_BOTTOM: clip_bottom_reg <= cfg_data;
            endcase
        end
    end

    // Pipeline advance: everything moves when the output register is empty or its last point is taken.
    logic                 en;
    logic                 full_reg;
    logic [CNT_W-1:0]     idx_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic                 out_last;

    assign out_last     = idx_reg == (cnt_reg - CNT_W'(1));
    assign en           = !full_reg || (pt_out.ready && out_last);
    assign seg_in.ready = en;

    // Stage a: register the raw segment.
    logic      a_valid_reg;
    ecr_item_t a_item_reg;
    ecr_item_t a_item_next;

    always_comb
    begin
        a_item_next    = '0;
        a_item_next.x0 = seg_in.start_x;
        a_item_next.y0 = seg_in.start_y;
        a_item_next.x1 = seg_in.end_x;
        a_item_next.y1 = seg_in.end_y;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= seg_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_item_reg <= a_item_next;
        end
    end

    // Order by y, reject, and set up the slope division.
    ecr_item_t        s_item;
    diff_t            s_dx;
    diff_t            s_dy;
    logic [DVD_W-1:0] div1_dvd;
    logic [DVS_W-1:0] div1_dvs;

    always_comb
    begin
        s_item = a_item_reg;
        if (a_item_reg.y0 > a_item_reg.y1)
        begin
            s_item.x0 = a_item_reg.x1;
            s_item.y0 = a_item_reg.y1;
            s_item.x1 = a_item_reg.x0;
            s_item.y1 = a_item_reg.y0;
        end
        s_item.vis  = (s_item.y0 != s_item.y1) && (s_item.y1 > clip_top_reg)
                      && (s_item.y0 < clip_bottom_reg);
        s_dx        = ext(s_item.x1) - ext(s_item.x0);
        s_dy        = ext(s_item.y1) - ext(s_item.y0);
        s_item.sneg = s_dx[CW];
        div1_dvd    = DVD_W'(mag(s_dx)) << FRAC_BITS;
        div1_dvs    = DVS_W'(s_dy);
    end

    logic          d1_valid;
    logic [QW-1:0] d1_q;
    logic          d1_ovf;
    ecr_item_t     d1_item;

    ecr_div u_div_slope (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (a_valid_reg),
        .dividend  (div1_dvd),
        .divisor   (div1_dvs),
        .in_item   (s_item),
        .out_valid (d1_valid),
        .quotient  (d1_q),
        .ovf       (d1_ovf),
        .out_item  (d1_item)
    );

    // Stage b: saturated slope magnitude.
    logic          b_valid_reg;
    ecr_item_t     b_item_reg;
    logic [CW-1:0] b_smag_reg;
    logic [QW-1:0] b_lim;
    logic [QW-1:0] b_smag_full;

    always_comb
    begin
        b_lim       = d1_item.sneg ? SMAG_NEG : SMAG_POS;
        b_smag_full = (d1_ovf || (d1_q > b_lim)) ? b_lim : d1_q;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            b_valid_reg <= d1_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b_item_reg <= d1_item;
            b_smag_reg <= b_smag_full[CW-1:0];
        end
    end

    // Distances to the top and bottom edges, and the slope products.
    ecr_item_t       b_item;
    diff_t           b_dtop;
    diff_t           b_dbot;
    logic [2*CW-1:0] b_prod_top;
    logic [2*CW-1:0] b_prod_bot;

    always_comb
    begin
        b_item         = b_item_reg;
        b_item.cut_top = b_item_reg.y0 < clip_top_reg;
        b_item.cut_bot = b_item_reg.y1 > clip_bottom_reg;
        b_dtop         = ext(clip_top_reg) - ext(b_item_reg.y0);
        b_dbot         = ext(b_item_reg.y1) - ext(clip_bottom_reg);
        b_prod_top     = (2*CW)'(b_smag_reg) * (2*CW)'(b_dtop[CW-1:0]);
        b_prod_bot     = (2*CW)'(b_smag_reg) * (2*CW)'(b_dbot[CW-1:0]);
    end

    // Stage c: products registered.
    logic            c_valid_reg;
    ecr_item_t       c_item_reg;
    logic [2*CW-1:0] c_prod_top_reg;
    logic [2*CW-1:0] c_prod_bot_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            c_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_item_reg     <= b_item;
            c_prod_top_reg <= b_prod_top;
            c_prod_bot_reg <= b_prod_bot;
        end
    end

    // Cut at the top and bottom edges.
    ecr_item_t c_item;

    always_comb
    begin
        c_item = c_item_reg;
        if (c_item_reg.cut_top)
        begin
            c_item.x0 = add_sat(c_item_reg.x0, cap64(c_prod_top_reg >> FRAC_BITS),
                                c_item_reg.sneg);
            c_item.y0 = clip_top_reg;
        end
        if (c_item_reg.cut_bot)
        begin
            c_item.x1 = add_sat(c_item_reg.x1, cap64(c_prod_bot_reg >> FRAC_BITS),
                                !c_item_reg.sneg);
            c_item.y1 = clip_bottom_reg;
        end
    end

    // Stage d: vertically clipped segment.
    logic      d_valid_reg;
    ecr_item_t d_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d_item_reg <= c_item;
        end
    end

    // Order by x, classify, and set up the left cut.
    ecr_item_t d_item;
    diff_t     d_num;
    diff_t     d_db;
    diff_t     d_da;
    logic      d_mid;

    always_comb
    begin
        d_item = d_item_reg;
        if (d_item_reg.x0 > d_item_reg.x1)
        begin
            d_item.x0 = d_item_reg.x1;
            d_item.y0 = d_item_reg.y1;
            d_item.x1 = d_item_reg.x0;
            d_item.y1 = d_item_reg.y0;
        end
        d_item.all_left  = d_item.x1 <= clip_left_reg;
        d_item.all_right = !d_item.all_left && (d_item.x0 >= clip_right_reg);
        d_mid            = !d_item.all_left && !d_item.all_right;
        d_item.need_l    = d_mid && (d_item.x0 < clip_left_reg);
        d_item.need_r    = d_mid && (d_item.x1 > clip_right_reg);
        d_num            = ext(clip_left_reg) - ext(d_item.x0);
        d_db             = ext(d_item.y1) - ext(d_item.y0);
        d_da             = ext(d_item.x1) - ext(d_item.x0);
        d_item.da_zero   = d_da == '0;
        d_item.ineg      = d_num[CW] ^ d_db[CW] ^ d_da[CW];
    end

    // Stage e: left cut operands.
    logic        e_valid_reg;
    ecr_item_t   e_item_reg;
    logic [CW:0] e_num_reg;
    logic [CW:0] e_db_reg;
    logic [CW:0] e_da_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            e_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            e_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e_item_reg <= d_item;
            e_num_reg  <= mag(d_num);
            e_db_reg   <= mag(d_db);
            e_da_reg   <= mag(d_da);
        end
    end

    // Stage f: split product for the left cut.
    logic            f_valid_reg;
    ecr_item_t       f_item_reg;
    logic [PL_W-1:0] f_pl_reg;
    logic [PH_W-1:0] f_ph_reg;
    logic [CW:0]     f_da_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            f_valid_reg <= e_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            f_item_reg <= e_item_reg;
            f_pl_reg   <= PL_W'(e_num_reg) * PL_W'(e_db_reg[MUL_LO_W-1:0]);
            f_ph_reg   <= PH_W'(e_num_reg) * PH_W'(e_db_reg[CW:MUL_LO_W]);
            f_da_reg   <= e_da_reg;
        end
    end

    logic [DVD_W-1:0] div2_dvd;

    assign div2_dvd = DVD_W'(f_pl_reg) + (DVD_W'(f_ph_reg) << MUL_LO_W);

    logic          d2_valid;
    logic [QW-1:0] d2_q;
    logic          d2_ovf;
    ecr_item_t     d2_item;

    ecr_div u_div_left (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (f_valid_reg),
        .dividend  (div2_dvd),
        .divisor   (f_da_reg),
        .in_item   (f_item_reg),
        .out_valid (d2_valid),
        .quotient  (d2_q),
        .ovf       (d2_ovf),
        .out_item  (d2_item)
    );

    // Left cut point, and the segment moved onto the left edge.
    ecr_item_t g_item;

    always_comb
    begin
        g_item     = d2_item;
        g_item.y0o = d2_item.y0;
        g_item.ycl = d2_item.da_zero ? d2_item.y0
                     : add_sat(d2_item.y0, cap_q(d2_q, d2_ovf), d2_item.ineg);
        if (d2_item.need_l)
        begin
            g_item.x0 = clip_left_reg;
            g_item.y0 = g_item.ycl;
        end
    end

    // Stage g: segment after the left cut.
    logic      g_valid_reg;
    ecr_item_t g_item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            g_valid_reg <= d2_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g_item_reg <= g_item;
        end
    end

    // Set up the right cut from the current end points.
    ecr_item_t r_item;
    diff_t     r_num;
    diff_t     r_db;
    diff_t     r_da;

    always_comb
    begin
        r_item         = g_item_reg;
        r_num          = ext(clip_right_reg) - ext(g_item_reg.x0);
        r_db           = ext(g_item_reg.y1) - ext(g_item_reg.y0);
        r_da           = ext(g_item_reg.x1) - ext(g_item_reg.x0);
        r_item.da_zero = r_da == '0;
        r_item.ineg    = r_num[CW] ^ r_db[CW] ^ r_da[CW];
    end

    // Stage h: right cut operands.
    logic        h_valid_reg;
    ecr_item_t   h_item_reg;
    logic [CW:0] h_num_reg;
    logic [CW:0] h_db_reg;
    logic [CW:0] h_da_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            h_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            h_valid_reg <= g_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            h_item_reg <= r_item;
            h_num_reg  <= mag(r_num);
            h_db_reg   <= mag(r_db);
            h_da_reg   <= mag(r_da);
        end
    end

    // Stage i: split product for the right cut.
    logic            i_valid_reg;
    ecr_item_t       i_item_reg;
    logic [PL_W-1:0] i_pl_reg;
    logic [PH_W-1:0] i_ph_reg;
    logic [CW:0]     i_da_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            i_valid_reg <= h_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            i_item_reg <= h_item_reg;
            i_pl_reg   <= PL_W'(h_num_reg) * PL_W'(h_db_reg[MUL_LO_W-1:0]);
            i_ph_reg   <= PH_W'(h_num_reg) * PH_W'(h_db_reg[CW:MUL_LO_W]);
            i_da_reg   <= h_da_reg;
        end
    end

    logic [DVD_W-1:0] div3_dvd;

    assign div3_dvd = DVD_W'(i_pl_reg) + (DVD_W'(i_ph_reg) << MUL_LO_W);

    logic          d3_valid;
    logic [QW-1:0] d3_q;
    logic          d3_ovf;
    ecr_item_t     d3_item;

    ecr_div u_div_right (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (i_valid_reg),
        .dividend  (div3_dvd),
        .divisor   (i_da_reg),
        .in_item   (i_item_reg),
        .out_valid (d3_valid),
        .quotient  (d3_q),
        .ovf       (d3_ovf),
        .out_item  (d3_item)
    );

    // Right cut point and the polyline of this item.
    coord_t           ycr;
    coord_t           px   [0:NPTS-1];
    coord_t           py   [0:NPTS-1];
    logic [CNT_W-1:0] pcnt;

    always_comb
    begin
        ycr = d3_item.da_zero ? d3_item.y0
              : add_sat(d3_item.y0, cap_q(d3_q, d3_ovf), d3_item.ineg);
        for (int k = 0; k < NPTS; k++)
        begin
            px[k] = '0;
            py[k] = '0;
        end
        pcnt = '0;
        if (d3_item.vis)
        begin
            priority if (d3_item.all_left)
            begin
                px[0] = clip_left_reg;  py[0] = d3_item.y0;
                px[1] = clip_left_reg;  py[1] = d3_item.y1;
                pcnt  = CNT_W'(2);
            end
            else if (d3_item.all_right)
            begin
                px[0] = clip_right_reg; py[0] = d3_item.y0;
                px[1] = clip_right_reg; py[1] = d3_item.y1;
                pcnt  = CNT_W'(2);
            end
            else if (d3_item.need_l && d3_item.need_r)
            begin
                px[0] = clip_left_reg;  py[0] = d3_item.y0o;
                px[1] = clip_left_reg;  py[1] = d3_item.ycl;
                px[2] = d3_item.x0;     py[2] = d3_item.y0;
                px[3] = clip_right_reg; py[3] = ycr;
                px[4] = clip_right_reg; py[4] = d3_item.y1;
                pcnt  = CNT_W'(5);
            end
            else if (d3_item.need_l)
            begin
                px[0] = clip_left_reg;  py[0] = d3_item.y0o;
                px[1] = clip_left_reg;  py[1] = d3_item.ycl;
                px[2] = d3_item.x0;     py[2] = d3_item.y0;
                px[3] = d3_item.x1;     py[3] = d3_item.y1;
                pcnt  = CNT_W'(4);
            end
            else if (d3_item.need_r)
            begin
                px[0] = d3_item.x0;     py[0] = d3_item.y0;
                px[1] = clip_right_reg; py[1] = ycr;
                px[2] = clip_right_reg; py[2] = d3_item.y1;
                pcnt  = CNT_W'(3);
            end
            else
            begin
                px[0] = d3_item.x0;     py[0] = d3_item.y0;
                px[1] = d3_item.x1;     py[1] = d3_item.y1;
                pcnt  = CNT_W'(2);
            end
        end
    end

    // Output register: holds one item's points and sends one a cycle while pt_out is ready.
    coord_t pts_x_reg [0:NPTS-1];
    coord_t pts_y_reg [0:NPTS-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else if (en)
        begin
            full_reg <= d3_valid && (pcnt != '0);
            idx_reg  <= '0;
        end
        else if (pt_out.ready)
        begin
            idx_reg <= idx_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cnt_reg <= pcnt;
            for (int k = 0; k < NPTS; k++)
            begin
                pts_x_reg[k] <= px[k];
                pts_y_reg[k] <= py[k];
            end
        end
    end

    assign pt_out.valid      = full_reg;
    assign pt_out.point_x    = pts_x_reg[idx_reg];
    assign pt_out.point_y    = pts_y_reg[idx_reg];
    assign pt_out.last_point = out_last;

    // Checks on the output sequencing and the stall path.
    `include "edge_clip_to_rect_core_macros.svh"

    `ECR_ASSERT_IMPL(a_idx_in_range, full_reg, idx_reg < cnt_reg, "point index past count")
    `ECR_ASSERT_IMPL(a_cnt_range, full_reg, (cnt_reg >= MIN_PTS) && (cnt_reg <= CNT_W'(NPTS)), "bad point count")
    `ECR_ASSERT_IMPL(a_stall_blocks_input, pt_out.valid && !pt_out.ready, !seg_in.ready, "input taken while output stalled")
    `ECR_ASSERT_NEXT(a_stall_holds_point, full_reg && !pt_out.ready, full_reg && $stable(idx_reg), "stalled point moved")

endmodule
